### src/lbba_pkg.sv
// Shared types and constants for the label bounding box accumulator.
package lbba_pkg;

    // Command codes on the input word
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_VOXEL = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Status codes on the result word
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_X_SIZE  = 2'd0;
    localparam logic [1:0] REG_Y_SIZE  = 2'd1;
    localparam logic [1:0] REG_Z_SIZE  = 2'd2;
    localparam logic [1:0] REG_FEAT_CNT = 2'd3;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int CFG_W     = 13;
    localparam int OUT_W     = 12;
    localparam int CMP_W     = 17;
    localparam int EPOCH_W   = 3;
    localparam int OUT_DEPTH = 3;

    // One result word
    typedef struct packed {
        logic [1:0]       status;
        logic             seen;
        logic [OUT_W-1:0] min_x;
        logic [OUT_W-1:0] min_y;
        logic [OUT_W-1:0] min_z;
        logic [OUT_W-1:0] max_x;
        logic [OUT_W-1:0] max_y;
        logic [OUT_W-1:0] max_z;
    } t_result;

endpackage

### src/lbba_box_mem.sv
// Box table memory: one write port, one read port, registered read data.
module lbba_box_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 75
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/lbba_out_fifo.sv
// Small result queue between the update stage and the output port.
module lbba_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lbba_pkg::t_result i_push_data,
    output logic              o_valid,
    input  logic              i_ready,
    output lbba_pkg::t_result o_data,
    output logic [1:0]        o_count
);

    lbba_pkg::t_result r_mem [lbba_pkg::OUT_DEPTH];
    logic [1:0]        r_wp;
    logic [1:0]        r_rp;
    logic [1:0]        r_cnt;
    logic              w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign w_pop   = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == 2'(lbba_pkg::OUT_DEPTH - 1)) ? 2'd0 : r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == 2'(lbba_pkg::OUT_DEPTH - 1)) ? 2'd0 : r_rp + 2'd1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### src/label_bounding_box_accumulator_top.sv
// Top level: position counters, box table read-modify-write pipeline, config port.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+--------------------------------------
//  in       | input     | i_in_valid / o_in_ready    | command, feature_id, entry_index
//  out      | output    | o_out_valid / i_out_ready  | status, entry_seen, min/max x y z
//  config   | input     | psel/penable/pwrite/pready | x_size, y_size, z_size, feature_count
//
//  One word per cycle when not stalled: the word is accepted, the table is read at that edge,
//  and in the next cycle the entry is updated and written back; one write port sets the rate.
//  A write to the entry read in the same edge is forwarded to the next word.
//  After reset, and on every seventh clear, a clearing pass writes all MAX_FEATURES
//  entries, one per cycle; no word is accepted meanwhile, config writes still are.
//  A three-word result queue absorbs output stalls; input stalls once three words wait
//  in the update stage and the queue together.
module label_bounding_box_accumulator_top #(
    parameter int MAX_FEATURES = 4096,
    parameter int COORD_BITS   = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbba_pkg::APB_AW-1:0]    paddr,
    input  logic [lbba_pkg::APB_DW-1:0]    pwdata,
    output logic [lbba_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_command,
    input  logic [15:0]                    i_feature_id,
    input  logic [11:0]                    i_entry_index,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic                           o_entry_seen,
    output logic [lbba_pkg::OUT_W-1:0]     o_min_x,
    output logic [lbba_pkg::OUT_W-1:0]     o_min_y,
    output logic [lbba_pkg::OUT_W-1:0]     o_min_z,
    output logic [lbba_pkg::OUT_W-1:0]     o_max_x,
    output logic [lbba_pkg::OUT_W-1:0]     o_max_y,
    output logic [lbba_pkg::OUT_W-1:0]     o_max_z
);

    localparam int AW = $clog2(MAX_FEATURES);
    localparam int CB = COORD_BITS;
    localparam int SW = COORD_BITS + 1;
    localparam int EW = lbba_pkg::EPOCH_W;
    localparam int DW = 6 * COORD_BITS + lbba_pkg::EPOCH_W;
    localparam int CW = lbba_pkg::CMP_W;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_UPDATE,
        OP_READ
    } t_op;

    // config registers
    logic [lbba_pkg::CFG_W-1:0] r_x_size, r_y_size, r_z_size, r_feat_cnt;
    logic                       w_cfg_wr;

    // position counters
    logic [CB-1:0] r_pos_x, r_pos_y;
    logic [SW-1:0] r_pos_z;

    // epoch mark and clearing pass
    logic [EW-1:0] r_epoch;
    logic          r_clr_active;
    logic [AW-1:0] r_clr_cnt;

    // update stage
    logic          r_s1_valid;
    t_op           r_s1_op;
    logic [1:0]    r_s1_status;
    logic          r_s1_oor;
    logic [AW-1:0] r_s1_addr;
    logic [CB-1:0] r_s1_c [3];

    // forwarding of the last write
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [DW-1:0] r_fwd_data;

    // stage 0 signals
    logic          w_in_acc;
    logic [SW-1:0] w_xs, w_ys, w_zs;
    logic [CW-1:0] w_fc;
    logic          w_beyond, w_fid_oor, w_idx_oor;
    logic          w_x_last, w_y_last;
    t_op           w_op;
    logic [1:0]    w_status;
    logic          w_advance;
    logic [AW-1:0] w_raddr;
    logic [CW-1:0] w_idx_ext;

    // stage 1 signals
    logic [DW-1:0] w_rdata, w_entry, w_new;
    logic          w_seen;
    logic [CB-1:0] w_emin [3];
    logic [CB-1:0] w_emax [3];
    logic [CB-1:0] w_nmin [3];
    logic [CB-1:0] w_nmax [3];
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic          w_upd_wr;

    lbba_pkg::t_result w_res, w_out;
    logic [1:0]        w_fifo_cnt;

    // clamp a size register to 1 .. 2^COORD_BITS
    function automatic logic [SW-1:0] clamp_size(input logic [lbba_pkg::CFG_W-1:0] v);
        logic [CW-1:0] ve;
        logic [CW-1:0] lim;
        ve  = CW'(v);
        lim = CW'(1) << CB;
        if (ve == '0) begin
            clamp_size = SW'(1);
        end else if (ve > lim) begin
            clamp_size = SW'(lim);
        end else begin
            clamp_size = SW'(ve);
        end
    endfunction

    // ---------------- config port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size   <= 13'd4096;
            r_y_size   <= 13'd4096;
            r_z_size   <= 13'd1;
            r_feat_cnt <= 13'd4096;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                lbba_pkg::REG_X_SIZE:   r_x_size   <= pwdata[lbba_pkg::CFG_W-1:0];
                lbba_pkg::REG_Y_SIZE:   r_y_size   <= pwdata[lbba_pkg::CFG_W-1:0];
                lbba_pkg::REG_Z_SIZE:   r_z_size   <= pwdata[lbba_pkg::CFG_W-1:0];
                lbba_pkg::REG_FEAT_CNT: r_feat_cnt <= pwdata[lbba_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lbba_pkg::REG_X_SIZE:   prdata = lbba_pkg::APB_DW'(r_x_size);
            lbba_pkg::REG_Y_SIZE:   prdata = lbba_pkg::APB_DW'(r_y_size);
            lbba_pkg::REG_Z_SIZE:   prdata = lbba_pkg::APB_DW'(r_z_size);
            lbba_pkg::REG_FEAT_CNT: prdata = lbba_pkg::APB_DW'(r_feat_cnt);
            default:                prdata = '0;
        endcase
    end

    // ---------------- stage 0: decode and table read ----------------
    assign o_in_ready = !r_clr_active && ((3'(w_fifo_cnt) + 3'(r_s1_valid)) < 3'(lbba_pkg::OUT_DEPTH));
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_xs = clamp_size(r_x_size);
    assign w_ys = clamp_size(r_y_size);
    assign w_zs = clamp_size(r_z_size);
    assign w_fc = (CW'(r_feat_cnt) > CW'(MAX_FEATURES)) ? CW'(MAX_FEATURES) : CW'(r_feat_cnt);

    assign w_beyond  = (r_pos_z >= w_zs);
    assign w_fid_oor = (CW'(i_feature_id) >= w_fc);
    assign w_idx_ext = CW'(i_entry_index);
    assign w_idx_oor = (w_idx_ext >= CW'(MAX_FEATURES));
    assign w_x_last  = ((SW'(r_pos_x) + SW'(1)) >= w_xs);
    assign w_y_last  = ((SW'(r_pos_y) + SW'(1)) >= w_ys);

    // command decode
    always_comb begin
        w_op      = OP_NONE;
        w_status  = lbba_pkg::ST_OK;
        w_advance = 1'b0;
        w_raddr   = AW'(i_feature_id);
        case (i_command)
            lbba_pkg::CMD_VOXEL: begin
                if (w_beyond) begin
                    w_status = lbba_pkg::ST_BEYOND;
                end else begin
                    w_advance = 1'b1;
                    if (i_feature_id != 16'd0) begin
                        if (w_fid_oor) begin
                            w_status = lbba_pkg::ST_RANGE;
                        end else begin
                            w_op = OP_UPDATE;
                        end
                    end
                end
            end
            lbba_pkg::CMD_READ: begin
                w_op    = OP_READ;
                w_raddr = w_idx_ext[AW-1:0];
                if (w_idx_oor) begin
                    w_status = lbba_pkg::ST_RANGE;
                end
            end
            default: ;
        endcase
    end

    // position counters and epoch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_pos_z      <= '0;
            r_epoch      <= EW'(1);
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
        end else begin
            if (w_in_acc && (i_command == lbba_pkg::CMD_CLEAR)) begin
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_pos_z <= '0;
                if (r_epoch == {EW{1'b1}}) begin
                    r_epoch      <= EW'(1);
                    r_clr_active <= 1'b1;
                    r_clr_cnt    <= '0;
                end else begin
                    r_epoch <= r_epoch + EW'(1);
                end
            end else begin
                if (w_in_acc && w_advance) begin
                    if (w_x_last) begin
                        r_pos_x <= '0;
                        if (w_y_last) begin
                            r_pos_y <= '0;
                            r_pos_z <= r_pos_z + SW'(1);
                        end else begin
                            r_pos_y <= r_pos_y + CB'(1);
                        end
                    end else begin
                        r_pos_x <= r_pos_x + CB'(1);
                    end
                end
                // clearing pass steps when the write port is free
                if (r_clr_active && !w_upd_wr) begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                    if (AW'(r_clr_cnt) == AW'(MAX_FEATURES - 1)) begin
                        r_clr_active <= 1'b0;
                    end
                end
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_op    <= OP_NONE;
        end else begin
            r_s1_valid <= w_in_acc;
            r_s1_op    <= w_in_acc ? w_op : OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status <= w_status;
        r_s1_oor    <= w_idx_oor;
        r_s1_addr   <= w_raddr;
        r_s1_c[0]   <= r_pos_x;
        r_s1_c[1]   <= r_pos_y;
        r_s1_c[2]   <= r_pos_z[CB-1:0];
    end

    // ---------------- box table ----------------
    lbba_box_mem #(
        .DEPTH (MAX_FEATURES),
        .AW    (AW),
        .DW    (DW)
    ) u_box_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- stage 1: modify and write back ----------------
    assign w_entry = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : w_rdata;
    assign w_seen  = (w_entry[DW-1 -: EW] == r_epoch);

    // unpack entry and widen the box
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_emin[j] = w_entry[(6 - j) * CB - 1 -: CB];
            w_emax[j] = w_entry[(3 - j) * CB - 1 -: CB];
            if (!w_seen) begin
                w_nmin[j] = r_s1_c[j];
                w_nmax[j] = r_s1_c[j];
            end else begin
                w_nmin[j] = (r_s1_c[j] < w_emin[j]) ? r_s1_c[j] : w_emin[j];
                w_nmax[j] = (r_s1_c[j] > w_emax[j]) ? r_s1_c[j] : w_emax[j];
            end
        end
    end

    assign w_new = {r_epoch, w_nmin[0], w_nmin[1], w_nmin[2], w_nmax[0], w_nmax[1], w_nmax[2]};

    // write port: updates first, then the clearing pass
    assign w_upd_wr = r_s1_valid && (r_s1_op == OP_UPDATE);
    assign w_we     = w_upd_wr || r_clr_active;
    assign w_waddr  = w_upd_wr ? r_s1_addr : r_clr_cnt;
    assign w_wdata  = w_upd_wr ? w_new : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_upd_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= w_new;
    end

    // result word
    always_comb begin
        w_res        = '0;
        w_res.status = r_s1_status;
        if (r_s1_op == OP_READ) begin
            if (!r_s1_oor && w_seen) begin
                w_res.seen  = 1'b1;
                w_res.min_x = lbba_pkg::OUT_W'(w_emin[0]);
                w_res.min_y = lbba_pkg::OUT_W'(w_emin[1]);
                w_res.min_z = lbba_pkg::OUT_W'(w_emin[2]);
                w_res.max_x = lbba_pkg::OUT_W'(w_emax[0]);
                w_res.max_y = lbba_pkg::OUT_W'(w_emax[1]);
                w_res.max_z = lbba_pkg::OUT_W'(w_emax[2]);
            end else begin
                w_res.min_x = lbba_pkg::OUT_W'({CB{1'b1}});
                w_res.min_y = lbba_pkg::OUT_W'({CB{1'b1}});
                w_res.min_z = lbba_pkg::OUT_W'({CB{1'b1}});
            end
        end
    end

    // ---------------- output queue ----------------
    lbba_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (w_res),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (w_out),
        .o_count     (w_fifo_cnt)
    );

    assign o_status     = w_out.status;
    assign o_entry_seen = w_out.seen;
    assign o_min_x      = w_out.min_x;
    assign o_min_y      = w_out.min_y;
    assign o_min_z      = w_out.min_z;
    assign o_max_x      = w_out.max_x;
    assign o_max_y      = w_out.max_y;
    assign o_max_z      = w_out.max_z;

`ifndef SYNTHESIS
    // queue has room for every word leaving the update stage
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (w_fifo_cnt != 2'd3))
        else $error("result queue overflow");

    // an entry update never competes with the clearing pass
    a_no_upd_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !w_upd_wr)
        else $error("table update during clearing pass");

    // a pass always leaves the first live epoch behind
    a_pass_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_active) |-> (r_epoch == EW'(1)))
        else $error("wrong epoch after clearing pass");

    // a voxel past the volume end leaves the counters alone
    a_beyond_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_command == lbba_pkg::CMD_VOXEL) && w_beyond)
        |=> ($stable(r_pos_x) && $stable(r_pos_y) && $stable(r_pos_z)))
        else $error("counters moved on a voxel beyond the volume");
`endif

endmodule

### dv/label_bounding_box_accumulator_top_tb.sv
// Self-checking testbench for the per-label 3D bounding box accumulator.
module label_bounding_box_accumulator_top_tb;
    import lbba_pkg::*;

    localparam int          LABELS       = 4096;
    localparam int          COORD_SPAN   = 4096;
    localparam int unsigned CYCLE_CAP    = 2_000_000;
    localparam int unsigned RANDOM_WORDS = 1000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOT_LABELS   = 24;
    localparam int          SWEEP_VOXELS = 320;
    localparam int          DRAIN_TAIL   = 16;
    // command code the block leaves unused
    localparam logic [1:0]  CMD_SPARE    = 2'd3;

    // Tracks label boxes, seen flags and scan position; holds expected results.
    class bbox_tracker;
        int unsigned      x_size, y_size, z_size, feat_cnt;
        int unsigned      pos_x, pos_y, pos_z;
        logic [OUT_W-1:0] lo [LABELS][3];
        logic [OUT_W-1:0] hi [LABELS][3];
        bit               seen [LABELS];
        t_result          expected_q [$];
        int unsigned      mismatches;

        function new();
            x_size     = 4096;
            y_size     = 4096;
            z_size     = 1;
            feat_cnt   = 4096;
            pos_x      = 0;
            pos_y      = 0;
            pos_z      = 0;
            mismatches = 0;
            foreach (seen[i]) seen[i] = 1'b0;
        endfunction

        // zero acts as one, anything past the coordinate span as the span
        function int unsigned span(int unsigned v);
            if (v == 0) return 1;
            if (v > COORD_SPAN) return COORD_SPAN;
            return v;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned value);
            int unsigned v;
            v = value & 32'h1FFF;
            case (idx)
                REG_X_SIZE:   x_size   = v;
                REG_Y_SIZE:   y_size   = v;
                REG_Z_SIZE:   z_size   = v;
                REG_FEAT_CNT: feat_cnt = v;
                default: ;
            endcase
        endfunction

        // raster step: x fastest, then y, then z
        function void step_position();
            if (pos_x + 1 >= span(x_size)) begin
                pos_x = 0;
                if (pos_y + 1 >= span(y_size)) begin
                    pos_y = 0;
                    pos_z = pos_z + 1;
                end else begin
                    pos_y = pos_y + 1;
                end
            end else begin
                pos_x = pos_x + 1;
            end
        endfunction

        function void widen(logic [11:0] id);
            logic [OUT_W-1:0] coord [3];
            coord[0] = pos_x[OUT_W-1:0];
            coord[1] = pos_y[OUT_W-1:0];
            coord[2] = pos_z[OUT_W-1:0];
            for (int j = 0; j < 3; j++) begin
                if (!seen[id]) begin
                    lo[id][j] = coord[j];
                    hi[id][j] = coord[j];
                end else begin
                    if (coord[j] < lo[id][j]) lo[id][j] = coord[j];
                    if (coord[j] > hi[id][j]) hi[id][j] = coord[j];
                end
            end
            seen[id] = 1'b1;
        endfunction

        // Work out the result of one accepted word and queue it
        function void accept_word(logic [1:0] cmd, logic [15:0] fid, logic [11:0] idx);
            t_result     r;
            int unsigned fc;
            r  = '0;
            fc = (feat_cnt > LABELS) ? LABELS : feat_cnt;
            case (cmd)
                CMD_CLEAR: begin
                    pos_x = 0;
                    pos_y = 0;
                    pos_z = 0;
                    foreach (seen[i]) seen[i] = 1'b0;
                end
                CMD_VOXEL: begin
                    if (pos_z >= span(z_size)) begin
                        r.status = ST_BEYOND;
                    end else begin
                        if (fid != 0) begin
                            if (fid >= fc) r.status = ST_RANGE;
                            else widen(fid[11:0]);
                        end
                        step_position();
                    end
                end
                CMD_READ: begin
                    r.status = ST_OK;
                    if (seen[idx]) begin
                        r.seen  = 1'b1;
                        r.min_x = lo[idx][0];
                        r.min_y = lo[idx][1];
                        r.min_z = lo[idx][2];
                        r.max_x = hi[idx][0];
                        r.max_y = hi[idx][1];
                        r.max_z = hi[idx][2];
                    end else begin
                        r.min_x = '1;
                        r.min_y = '1;
                        r.min_z = '1;
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one delivered result with the oldest expected one
        function void match_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result with nothing outstanding: status %0d", got.status);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("status",     OUT_W'(want.status), OUT_W'(got.status));
            check_field("entry_seen", OUT_W'(want.seen),   OUT_W'(got.seen));
            check_field("min_x",      want.min_x,  got.min_x);
            check_field("min_y",      want.min_y,  got.min_y);
            check_field("min_z",      want.min_z,  got.min_z);
            check_field("max_x",      want.max_x,  got.max_x);
            check_field("max_y",      want.max_y,  got.max_y);
            check_field("max_z",      want.max_z,  got.max_z);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_command = CMD_CLEAR;
    logic [15:0]       i_feature_id = '0;
    logic [11:0]       i_entry_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_status;
    logic              o_entry_seen;
    logic [OUT_W-1:0]  o_min_x, o_min_y, o_min_z, o_max_x, o_max_y, o_max_z;

    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 84;
    bit          hold_req = 1'b0;
    int unsigned cycles = 0;
    bbox_tracker book;

    label_bounding_box_accumulator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_feature_id  (i_feature_id),
        .i_entry_index (i_entry_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_seen  (o_entry_seen),
        .o_min_x       (o_min_x),
        .o_min_y       (o_min_y),
        .o_min_z       (o_min_z),
        .o_max_x       (o_max_x),
        .o_max_y       (o_max_y),
        .o_max_z       (o_max_z)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog and result check at the rising edge
    always @(posedge i_clk) begin
        t_result got;
        cycles = cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_status, o_entry_seen, o_min_x, o_min_y, o_min_z,
                   o_max_x, o_max_y, o_max_z};
            book.match_result(got);
        end
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word; returns at the edge where it is taken
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] fid,
                             input logic [11:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command     = cmd;
        i_feature_id  = fid;
        i_entry_index = idx;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.accept_word(cmd, fid, idx);
    endtask

    // Stop offering and wait for every expected result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (book.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        book.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_volume(input int unsigned xs, input int unsigned ys,
                              input int unsigned zs, input int unsigned fc);
        write_reg(REG_X_SIZE, xs);
        write_reg(REG_Y_SIZE, ys);
        write_reg(REG_Z_SIZE, zs);
        write_reg(REG_FEAT_CNT, fc);
    endtask

    // mostly tiny sizes, sometimes zero, the span or the 13-bit maximum
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) return 0;
        if (r < 10) return 8191;
        if (r < 14) return 4096;
        if (r < 18) return $urandom_range(8191);
        return $urandom_range(5, 1);
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 12) return 4096;
        if (r < 16) return 8191;
        if (r < 20) return $urandom_range(8191);
        return $urandom_range(30, 1);
    endfunction

    // background, noise, the boundary label, or one of a few hot labels
    function automatic logic [15:0] pick_label(int unsigned fc);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 16'd0;
        if (r < 25) return 16'($urandom_range(65535));
        if (r < 30) return fc[15:0];
        if (fc >= 2)
            return 16'($urandom_range((fc - 1 < HOT_LABELS) ? fc - 1 : HOT_LABELS, 1));
        return 16'($urandom_range(HOT_LABELS, 1));
    endfunction

    // Main sequence
    initial begin
        int unsigned xs, ys, zs, fc, cells, r, phase, random_words;
        book = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: one 3x2x2 volume with 10 labels, walked past its end
        set_volume(3, 2, 2, 10);
        send_word(CMD_READ,  16'd0,      12'd5);
        send_word(CMD_VOXEL, 16'd0,      12'd0);
        send_word(CMD_VOXEL, 16'd5,      12'd0);
        send_word(CMD_VOXEL, 16'd10,     12'd0);
        send_word(CMD_VOXEL, 16'hFFFF,   12'hFFF);
        send_word(CMD_VOXEL, 16'd5,      12'd0);
        send_word(CMD_VOXEL, 16'd9,      12'd0);
        send_word(CMD_VOXEL, 16'd1,      12'd0);
        send_word(CMD_VOXEL, 16'd0,      12'd0);
        send_word(CMD_VOXEL, 16'd5,      12'd0);
        send_word(CMD_VOXEL, 16'h8000,   12'd0);
        send_word(CMD_VOXEL, 16'd5,      12'd0);
        send_word(CMD_VOXEL, 16'd1,      12'd0);
        send_word(CMD_VOXEL, 16'd7,      12'd0);
        send_word(CMD_VOXEL, 16'd0,      12'd0);
        send_word(CMD_READ,  16'd0,      12'd5);
        send_word(CMD_READ,  16'd0,      12'd9);
        send_word(CMD_READ,  16'd0,      12'd1);
        send_word(CMD_READ,  16'hFFFF,   12'hFFF);
        send_word(CMD_SPARE, 16'hFFFF,   12'hFFF);
        send_word(CMD_CLEAR, 16'd0,      12'd0);
        send_word(CMD_READ,  16'd0,      12'd5);
        send_word(CMD_VOXEL, 16'd5,      12'd0);
        send_word(CMD_READ,  16'd0,      12'd5);

        // Random volumes: clear, scan with stray reads and noise, read back
        phase        = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            drain();
            if (random_words < RANDOM_WORDS / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 84;
            end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            xs = pick_size();
            ys = pick_size();
            zs = pick_size();
            fc = pick_count();
            set_volume(xs, ys, zs, fc);
            cells = book.span(xs) * book.span(ys);
            cells = (cells > 60) ? 60 : cells * book.span(zs);
            if (cells > 60) cells = 60;
            send_word(CMD_CLEAR, 16'($urandom_range(65535)), 12'($urandom_range(4095)));
            if (phase % 4 == 1) hold_req = 1'b1;
            for (int n = 0; n < cells + 3; n++) begin
                r = $urandom_range(99);
                if (r < 8)
                    send_word(CMD_READ, 16'($urandom_range(65535)),
                              12'($urandom_range(HOT_LABELS)));
                else if (r < 10)
                    send_word(CMD_READ, 16'($urandom_range(65535)),
                              12'($urandom_range(4095)));
                else if (r < 11)
                    send_word(CMD_CLEAR, 16'($urandom_range(65535)),
                              12'($urandom_range(4095)));
                else if (r < 13)
                    send_word(CMD_SPARE, 16'($urandom_range(65535)),
                              12'($urandom_range(4095)));
                else
                    send_word(CMD_VOXEL, pick_label(fc), 12'($urandom_range(4095)));
                if (r >= 13 || r < 11) random_words++;
            end
            for (int l = 0; l <= HOT_LABELS + 1; l++) begin
                send_word(CMD_READ, 16'($urandom_range(65535)), 12'(l));
                random_words++;
            end
            phase++;
        end

        // Long row: sizes past the span or zero, labels spread along one row
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_volume(8191, 0, 2, 8191);
        send_word(CMD_CLEAR, 16'd0, 12'd0);
        for (int n = 0; n < SWEEP_VOXELS; n++) begin
            if ($urandom_range(99) < 4)
                send_word(CMD_VOXEL, 16'($urandom_range(HOT_LABELS, 1)), 12'd0);
            else
                send_word(CMD_VOXEL, 16'd0, 12'd0);
        end
        for (int l = 0; l <= HOT_LABELS + 1; l++) send_word(CMD_READ, 16'd0, 12'(l));

        drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (book.mismatches == 0 && book.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
src/lbba_pkg.sv
src/lbba_box_mem.sv
src/lbba_out_fifo.sv
src/label_bounding_box_accumulator_top.sv
dv/label_bounding_box_accumulator_top_tb.sv
